[src/bmdf_pkg.sv]
// Shared types, constants and helpers of the block matrix difference filter.
package bmdf_pkg;

  localparam int DEF_MAX_BLOCK_SIZE = 16;
  localparam int DEF_MAX_BLOCK_COUNT = 16;
  localparam int DEF_MAX_ORDER = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W = 16;
  localparam int OUT_W = 48;
  localparam int POS_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_SIZE  = 3'd0,
    REG_BLOCK_COUNT = 3'd1,
    REG_DIFF_ORDER  = 3'd2,
    REG_COEF_ZERO   = 3'd3,
    REG_COEF_ONE    = 3'd4,
    REG_COEF_TWO    = 3'd5,
    REG_COEF_THREE  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [4:0] block_size;
    logic [4:0] block_count;
    logic [1:0] diff_order;
    logic signed [COEF_W-1:0] coef_zero;
    logic signed [COEF_W-1:0] coef_one;
    logic signed [COEF_W-1:0] coef_two;
    logic signed [COEF_W-1:0] coef_three;
  } cfg_t;

  function automatic logic [4:0] clamp_size(input logic [4:0] v, input int hi);
    logic [4:0] res;
    res = v;
    if (v == 5'd0) res = 5'd1;
    else if (int'(v) > hi) res = 5'(hi);
    return res;
  endfunction

  function automatic logic [1:0] clamp_order(input logic [1:0] v, input int hi);
    logic [1:0] res;
    res = v;
    if (int'(v) > hi) res = 2'(hi);
    return res;
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef(input cfg_t cfg,
                                                        input logic [1:0] k);
    logic signed [COEF_W-1:0] res;
    case (k)
      2'd0: res = cfg.coef_zero;
      2'd1: res = cfg.coef_one;
      2'd2: res = cfg.coef_two;
      default: res = cfg.coef_three;
    endcase
    return res;
  endfunction

endpackage

[src/bmdf_front.sv]
// Front end: tracks the matrix position of each input word and classifies it.
module bmdf_front import bmdf_pkg::*; #(
  parameter int MAX_BLOCK_SIZE = DEF_MAX_BLOCK_SIZE,
  parameter int MAX_BLOCK_COUNT = DEF_MAX_BLOCK_COUNT,
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic restart,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic job_valid,
  input  logic job_ready,
  output logic [32+$clog2(MAX_ORDER*MAX_BLOCK_SIZE+1)
               +$clog2(MAX_BLOCK_SIZE*MAX_BLOCK_COUNT+1)+2+2*POS_W-1:0] job
);

  localparam int STORE_ROWS = MAX_ORDER * MAX_BLOCK_SIZE + 1;
  localparam int SR_W = $clog2(STORE_ROWS);
  localparam int IDX_W = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_COUNT + 1);

  logic [IDX_W-1:0] row_index, col_index, row_next, col_next;
  logic [SR_W-1:0] store_row, store_row_next;
  logic [4:0] bs, bc;
  logic [1:0] d;
  logic [15:0] side, lag, r0, c0, c1, r1;
  logic [SR_W-1:0] sr0;
  logic wrap, emit, last;
  logic accept;

  assign bs = clamp_size(cfg.block_size, MAX_BLOCK_SIZE);
  assign bc = clamp_size(cfg.block_count, MAX_BLOCK_COUNT);
  assign d = clamp_order(cfg.diff_order, MAX_ORDER);
  assign side = {11'd0, bs} * {11'd0, bc};
  assign lag = {14'd0, d} * {11'd0, bs};

  assign wrap = (16'(row_index) >= side) || (16'(col_index) >= side);
  assign r0 = wrap ? 16'd0 : 16'(row_index);
  assign c0 = wrap ? 16'd0 : 16'(col_index);
  assign sr0 = wrap ? '0 : store_row;
  assign emit = ({14'd0, d} < {11'd0, bc}) && (r0 >= lag) && (c0 >= lag);
  assign last = (r0 == side - 16'd1) && (c0 == side - 16'd1);

  assign c1 = c0 + 16'd1;
  assign r1 = r0 + 16'd1;

  always_comb begin
    row_next = IDX_W'(r0);
    col_next = IDX_W'(c1);
    store_row_next = sr0;
    if (c1 >= side) begin
      col_next = '0;
      row_next = IDX_W'(r1);
      store_row_next = (int'(sr0) == STORE_ROWS - 1) ? '0 : sr0 + SR_W'(1);
      if (r1 >= side) begin
        row_next = '0;
        store_row_next = '0;
      end
    end
  end

  assign in_ready = job_ready;
  assign job_valid = in_valid;
  assign accept = in_valid && in_ready;
  assign job = {sample, sr0, IDX_W'(c0), emit, last, 8'(r0 - lag), 8'(c0 - lag)};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_index <= '0;
      col_index <= '0;
      store_row <= '0;
    end else if (accept) begin
      row_index <= row_next;
      col_index <= col_next;
      store_row <= store_row_next;
    end
  end

endmodule

[src/bmdf_queue.sv]
// Short first-in first-out queue between the front and back ends.
module bmdf_queue import bmdf_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign push_ready = (int'(count) < DEPTH);
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

[src/bmdf_back.sv]
// Back end: row store, tap sequencer, multiply-accumulate and output register.
module bmdf_back import bmdf_pkg::*; #(
  parameter int MAX_BLOCK_SIZE = DEF_MAX_BLOCK_SIZE,
  parameter int MAX_BLOCK_COUNT = DEF_MAX_BLOCK_COUNT,
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic job_valid,
  output logic job_ready,
  input  logic [32+$clog2(MAX_ORDER*MAX_BLOCK_SIZE+1)
               +$clog2(MAX_BLOCK_SIZE*MAX_BLOCK_COUNT+1)+2+2*POS_W-1:0] job,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [OUT_W-1:0] filtered,
  output logic [POS_W-1:0] out_row,
  output logic [POS_W-1:0] out_col,
  output logic final_res
);

  localparam int STORE_ROWS = MAX_ORDER * MAX_BLOCK_SIZE + 1;
  localparam int STORE_COLS = MAX_BLOCK_SIZE * MAX_BLOCK_COUNT;
  localparam int SR_W = $clog2(STORE_ROWS);
  localparam int IDX_W = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_COUNT + 1);
  localparam int DEPTH = STORE_ROWS * STORE_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int ACC_W = 68;
  localparam int RND_W = ACC_W - 24;
  localparam logic signed [63:0] POS_LIM = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] NEG_LIM = -64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {IDLE, TAPS, DRAIN, DONE} state_t;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;
  logic [AW-1:0] addr;
  logic we;

  logic signed [SAMPLE_W-1:0] j_sample;
  logic [SR_W-1:0] j_srow;
  logic [IDX_W-1:0] j_col;
  logic j_emit, j_final;
  logic [POS_W-1:0] j_orow, j_ocol;

  state_t state;
  logic [1:0] t, s, d;
  logic [4:0] bs;
  logic [SR_W-1:0] rowp;
  logic [IDX_W-1:0] colp, base_col;
  logic [POS_W-1:0] res_row, res_col;
  logic res_final;

  logic p1_valid, p1_last, p2_valid, p2_last;
  logic signed [31:0] cc;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc, rsum;
  logic signed [RND_W-1:0] rnd;
  logic signed [63:0] rnd64, sat;
  logic start;

  assign {j_sample, j_srow, j_col, j_emit, j_final, j_orow, j_ocol} = job;
  assign bs = clamp_size(cfg.block_size, MAX_BLOCK_SIZE);
  assign d = clamp_order(cfg.diff_order, MAX_ORDER);
  assign job_ready = (state == IDLE);
  assign start = job_valid && job_ready;

  always_comb begin
    if (state == IDLE) addr = AW'(j_srow) * AW'(STORE_COLS) + AW'(j_col);
    else addr = AW'(rowp) * AW'(STORE_COLS) + AW'(colp);
  end
  assign we = start;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= j_sample;
    rdata <= mem[addr];
  end

  assign rsum = acc + ACC_W'(24'h80_0000);
  assign rnd = RND_W'(rsum >>> 24);
  assign rnd64 = 64'(rnd);
  always_comb begin
    sat = rnd64;
    if (rnd64 > POS_LIM) sat = POS_LIM;
    else if (rnd64 < NEG_LIM) sat = NEG_LIM;
  end

  always_ff @(posedge clk) begin
    cc <= pick_coef(cfg, t) * pick_coef(cfg, s);
    prod <= 64'(cc) * 64'(rdata);
    p1_last <= (state == TAPS) && (s == d) && (t == d);
    p2_last <= p1_last;
    if (start) acc <= '0;
    else if (p2_valid) acc <= acc + ACC_W'(prod);
    if (rst) begin
      state <= IDLE;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= (state == TAPS);
      p2_valid <= p1_valid;
      if (out_valid && out_ready && (state != DONE)) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start && j_emit) begin
            state <= TAPS;
            t <= 2'd0;
            s <= 2'd0;
            rowp <= j_srow;
            colp <= j_col;
            base_col <= j_col;
            res_row <= j_orow;
            res_col <= j_ocol;
            res_final <= j_final;
          end
        end
        TAPS: begin
          if (s == d) begin
            s <= 2'd0;
            colp <= base_col;
            if (t == d) begin
              state <= DRAIN;
            end else begin
              t <= t + 2'd1;
              if (16'(rowp) >= 16'(bs)) rowp <= SR_W'(16'(rowp) - 16'(bs));
              else rowp <= SR_W'(16'(rowp) + 16'(STORE_ROWS) - 16'(bs));
            end
          end else begin
            s <= s + 2'd1;
            colp <= IDX_W'(16'(colp) - 16'(bs));
          end
        end
        DRAIN: begin
          if (p2_valid && p2_last) state <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            filtered <= OUT_W'(sat);
            out_row <= res_row;
            out_col <= res_col;
            final_res <= res_final;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[src/block_matrix_difference_filter.sv]
// Block matrix difference filter: takes one matrix element per word and emits the
// block-differenced element once its taps are in the row store. The back end takes
// a new word only when idle; a word that yields a result keeps it busy through its
// (diff_order+1)^2 taps, the drain and the output register, and the single-port row
// store gives one tap per cycle to the multiply-accumulate pipeline. A four-word queue
// lets input words arrive while the back end works. The row store needs no clearing.
module block_matrix_difference_filter import bmdf_pkg::*; #(
  parameter int MAX_BLOCK_SIZE = DEF_MAX_BLOCK_SIZE,
  parameter int MAX_BLOCK_COUNT = DEF_MAX_BLOCK_COUNT,
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [OUT_W-1:0] filtered,
  output logic [POS_W-1:0] out_row,
  output logic [POS_W-1:0] out_col,
  output logic final_res
);

  localparam int JOB_W = 32 + $clog2(MAX_ORDER * MAX_BLOCK_SIZE + 1)
                         + $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_COUNT + 1) + 2 + 2 * POS_W;

  cfg_t cfg;
  logic restart;
  logic f_valid, f_ready, b_valid, b_ready;
  logic [JOB_W-1:0] f_job, b_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b0;
      cfg.block_size <= 5'd1;
      cfg.block_count <= 5'd1;
      cfg.diff_order <= 2'd1;
      cfg.coef_zero <= 16'sd4096;
      cfg.coef_one <= -16'sd4096;
      cfg.coef_two <= '0;
      cfg.coef_three <= '0;
    end else begin
      restart <= cfg_valid && cfg_ready && (cfg_index <= REG_COEF_THREE);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCK_SIZE: cfg.block_size <= cfg_data[4:0];
          REG_BLOCK_COUNT: cfg.block_count <= cfg_data[4:0];
          REG_DIFF_ORDER: cfg.diff_order <= cfg_data[1:0];
          REG_COEF_ZERO: cfg.coef_zero <= cfg_data;
          REG_COEF_ONE: cfg.coef_one <= cfg_data;
          REG_COEF_TWO: cfg.coef_two <= cfg_data;
          REG_COEF_THREE: cfg.coef_three <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  bmdf_front #(
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE),
    .MAX_BLOCK_COUNT(MAX_BLOCK_COUNT),
    .MAX_ORDER(MAX_ORDER)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(restart),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  bmdf_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_job)
  );

  bmdf_back #(
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE),
    .MAX_BLOCK_COUNT(MAX_BLOCK_COUNT),
    .MAX_ORDER(MAX_ORDER)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid(out_valid), .out_ready(out_ready), .filtered(filtered),
    .out_row(out_row), .out_col(out_col), .final_res(final_res)
  );

`ifndef SYNTHESIS
  a_final_square: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_res |-> out_row == out_col)
    else $error("Last word of the output matrix is off the diagonal.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output word valid right after reset.");

  a_accept_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> f_ready)
    else $error("Input word accepted while the queue is full.");
`endif

endmodule
